[hdl/olr_pkg.sv]
`default_nettype none
package olr_pkg;

   localparam logic [1:0] FUNC_LOG   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [7:0] RESTORED_CODE_RESET = 8'd2;

   localparam int COUNT_W = 6;

   typedef struct packed {
      logic [31:0] service_index;
      logic [7:0]  change_type;
      logic [63:0] expected_value;
      logic [63:0] actual_value;
      logic        restored;
      logic [63:0] event_time;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      entry_type            entry;
      logic [COUNT_W-1:0]   returned;
      logic                 valid;
      logic                 last;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/olr_ram.sv]
`default_nettype none
module olr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hdl/overwrite_ring_event_log_top.sv]
// Overwriting circular event log.
// req channel: tuser carries the function (log, read, clear), tdata the event
// fields and the read limit. rsp channel: tuser is the entry-valid flag, tlast
// marks the final result of an input, tdata the stored entry and the running
// count. csr channel: one write sets the restored change-type code.
// A log or clear transfer returns one acknowledgement, buffered in the cycle
// after the transfer. A read returns one result per entry, oldest first, up to
// the limit; the first passes the read state, RAM read and output buffer, then
// one entry per cycle while the receiver keeps up, paced by the RAM's single
// read port and a two-entry output buffer. An empty read returns one invalid
// marker. Log and clear transfers are accepted every cycle while the receiver
// keeps up; a read holds off requests until its last entry is buffered.
// Unused function code 3 is accepted and gives no result.
// Reset empties the log (head and tail to zero), clears the output buffer and
// sets the restored code to 2. Entry RAM contents are not cleared.
// When the receiver stalls, results wait in the output buffer and RAM reads
// stop once the buffer has no room left; nothing is dropped.
`default_nettype none
module overwrite_ring_event_log_top
   import olr_pkg::*;
#(
   parameter int ENTRY_COUNT = 64
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // service_index[31:0], change_type[39:32], expected_value[103:40],
   // actual_value[167:104], event_time[231:168], read_limit[237:232], zero pad
   input  wire [239:0]  req_tdata,
   // func[1:0]
   input  wire [1:0]    req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // out_service_index[31:0], out_change_type[39:32], out_expected[103:40],
   // out_actual[167:104], out_restored[168], out_time[232:169],
   // entries_returned[238:233], zero pad
   output logic [239:0] rsp_tdata,
   // entry_valid[0]
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire [7:0]    csr_data
);

   localparam int PTR_W = $clog2(ENTRY_COUNT);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ENTRY_COUNT - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   logic               state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [7:0]         code_ff;
   logic               inflight_ff;
   logic [COUNT_W-1:0] meta_n_ff;
   logic               meta_last_ff;

   rsp_type            fifo_ff [2];
   logic [1:0]         count_ff;
   logic               wr_sel_ff;
   logic               rd_sel_ff;

   logic               req_xfer;
   logic               pop;
   logic               push_ack;
   logic               push;
   rsp_type            push_data;
   logic [2:0]         credit_use;
   logic               issue;
   logic               issue_last;
   logic [PTR_W-1:0]   rd_next;
   logic [COUNT_W-1:0] n_next;

   logic               ram_wr_en;
   entry_type          ram_wr_data;
   entry_type          ram_rd_data;

   logic [COUNT_W-1:0] req_limit;
   logic               read_empty;

   assign req_limit  = req_tdata[237:232];
   assign read_empty = (head_ff == tail_ff) || (req_limit == '0);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !inflight_ff && (count_ff != 2'd2);
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign credit_use = {1'b0, count_ff} + {2'b0, inflight_ff} - {2'b0, pop};
   assign issue      = (state_ff == ST_READ) && (credit_use < 3'd2);
   assign rd_next    = next_slot(rd_ptr_ff);
   assign n_next     = n_ff + 1'b1;
   assign issue_last = (rd_next == tail_ff) || (n_next == limit_ff);

   assign ram_wr_en = req_xfer && (req_tuser == FUNC_LOG);
   always_comb begin
      ram_wr_data.service_index  = req_tdata[31:0];
      ram_wr_data.change_type    = req_tdata[39:32];
      ram_wr_data.expected_value = req_tdata[103:40];
      ram_wr_data.actual_value   = req_tdata[167:104];
      ram_wr_data.event_time     = req_tdata[231:168];
      ram_wr_data.restored       = (req_tdata[39:32] == code_ff);
   end

   olr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      push_ack = 1'b0;
      if (req_xfer) begin
         case (req_tuser)
            FUNC_LOG, FUNC_CLEAR: push_ack = 1'b1;
            FUNC_READ:            push_ack = read_empty;
            default:              push_ack = 1'b0;
         endcase
      end
   end

   assign push = push_ack || inflight_ff;

   always_comb begin
      if (inflight_ff) begin
         push_data.entry    = ram_rd_data;
         push_data.returned = meta_n_ff;
         push_data.valid    = 1'b1;
         push_data.last     = meta_last_ff;
      end else begin
         push_data.entry    = '0;
         push_data.returned = '0;
         push_data.valid    = 1'b0;
         push_data.last     = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      rd_ptr_in = rd_ptr_ff;
      n_in      = n_ff;
      limit_in  = limit_ff;
      if (req_xfer) begin
         case (req_tuser)
            FUNC_LOG: begin
               tail_in = next_slot(tail_ff);
               if (next_slot(tail_ff) == head_ff) begin
                  head_in = next_slot(head_ff);
               end
            end
            FUNC_READ: begin
               rd_ptr_in = head_ff;
               n_in      = '0;
               limit_in  = req_limit;
               if (!read_empty) begin
                  state_in = ST_READ;
               end
            end
            FUNC_CLEAR: begin
               head_in = '0;
               tail_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (issue) begin
         rd_ptr_in = rd_next;
         n_in      = n_next;
         if (issue_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         code_ff     <= RESTORED_CODE_RESET;
         inflight_ff <= 1'b0;
         count_ff    <= 2'd0;
         wr_sel_ff   <= 1'b0;
         rd_sel_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         inflight_ff <= issue;
         if (csr_valid && csr_ready) begin
            code_ff <= csr_data;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         if (push) begin
            wr_sel_ff <= !wr_sel_ff;
         end
         if (pop) begin
            rd_sel_ff <= !rd_sel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      n_ff      <= n_in;
      limit_ff  <= limit_in;
      if (issue) begin
         meta_n_ff    <= n_next;
         meta_last_ff <= issue_last;
      end
      if (push) begin
         fifo_ff[wr_sel_ff] <= push_data;
      end
   end

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[31:0]    = fifo_ff[rd_sel_ff].entry.service_index;
      rsp_tdata[39:32]   = fifo_ff[rd_sel_ff].entry.change_type;
      rsp_tdata[103:40]  = fifo_ff[rd_sel_ff].entry.expected_value;
      rsp_tdata[167:104] = fifo_ff[rd_sel_ff].entry.actual_value;
      rsp_tdata[168]     = fifo_ff[rd_sel_ff].entry.restored;
      rsp_tdata[232:169] = fifo_ff[rd_sel_ff].entry.event_time;
      rsp_tdata[238:233] = fifo_ff[rd_sel_ff].returned;
      rsp_tuser[0]       = fifo_ff[rd_sel_ff].valid;
      rsp_tlast          = fifo_ff[rd_sel_ff].last;
   end

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && (count_ff == 2'd2) |-> pop)
      else $error("push into full output buffer");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !inflight_ff && (state_ff == ST_IDLE))
      else $error("request taken while a read is in progress");

   a_write_read_apart: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !issue)
      else $error("entry write and read in the same cycle");

   a_read_ends: assert property (@(posedge clock) disable iff (reset)
      issue && issue_last |=> (state_ff == ST_IDLE) && inflight_ff)
      else $error("read did not finish after its last entry");

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
   import olr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] idx;
      logic [7:0]  ct;
      logic [63:0] exp_v;
      logic [63:0] act_v;
      logic [63:0] tm;
      logic [5:0]  lim;
   } req_item_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [239:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [239:0]  rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [7:0]    csr_data = '0;

   req_item_t     pending_reqs[$];
   req_item_t     next_req = '0;
   rsp_type       awaited_results[$];
   entry_type     ring[64];
   logic [5:0]    ring_head = '0;
   logic [5:0]    ring_tail = '0;
   logic [7:0]    restored_code = RESTORED_CODE_RESET;
   logic          req_took = 1'b0;
   logic          calm = 1'b0;
   int            req_gap = 0;
   int            stall_left = 0;
   int            queued_total = 0;
   int            taken_total = 0;
   int            failures = 0;

   overwrite_ring_event_log_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic predict_log_op(input req_item_t it);
      rsp_type    r;
      logic [5:0] p;
      int         n;
      r = '0;
      r.last = 1'b1;
      case (it.func)
         FUNC_LOG: begin
            if (ring_tail + 6'd1 == ring_head) ring_head = ring_head + 6'd1;
            ring[ring_tail].service_index  = it.idx;
            ring[ring_tail].change_type    = it.ct;
            ring[ring_tail].expected_value = it.exp_v;
            ring[ring_tail].actual_value   = it.act_v;
            ring[ring_tail].restored       = (it.ct == restored_code);
            ring[ring_tail].event_time     = it.tm;
            ring_tail = ring_tail + 6'd1;
            awaited_results.push_back(r);
         end
         FUNC_READ: begin
            p = ring_head;
            n = 0;
            while (p != ring_tail && n < int'(it.lim)) begin
               r.entry = ring[p];
               r.valid = 1'b1;
               r.returned = 6'(n + 1);
               r.last = 1'b0;
               awaited_results.push_back(r);
               n++;
               p = p + 6'd1;
            end
            if (n == 0) begin
               awaited_results.push_back(r);
            end else begin
               r = awaited_results.pop_back();
               r.last = 1'b1;
               awaited_results.push_back(r);
            end
         end
         FUNC_CLEAR: begin
            ring_head = '0;
            ring_tail = '0;
            awaited_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   function automatic void compare_field(string name, logic [63:0] want_v,
                                         logic [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
         failures++;
      end
   endfunction

   task automatic check_result();
      rsp_type want;
      rsp_type got;
      got.entry    = {rsp_tdata[31:0], rsp_tdata[39:32], rsp_tdata[103:40],
                      rsp_tdata[167:104], rsp_tdata[168], rsp_tdata[232:169]};
      got.returned = rsp_tdata[238:233];
      got.valid    = rsp_tuser[0];
      got.last     = rsp_tlast;
      if (awaited_results.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %h", $time, got);
         failures++;
      end else begin
         want = awaited_results.pop_front();
         compare_field("entry_valid", want.valid, got.valid);
         compare_field("service_index", want.entry.service_index, got.entry.service_index);
         compare_field("change_type", want.entry.change_type, got.entry.change_type);
         compare_field("expected_value", want.entry.expected_value,
                       got.entry.expected_value);
         compare_field("actual_value", want.entry.actual_value, got.entry.actual_value);
         compare_field("restored", want.entry.restored, got.entry.restored);
         compare_field("event_time", want.entry.event_time, got.entry.event_time);
         compare_field("entries_returned", want.returned, got.returned);
         compare_field("last", want.last, got.last);
      end
   endtask

   // request side: one transfer per handshake, random gaps afterwards
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, next_req.lim, next_req.tm, next_req.act_v,
                          next_req.exp_v, next_req.ct, next_req.idx};
            req_tuser <= next_req.func;
            if (!calm && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 7);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            taken_total++;
            predict_log_op(next_req);
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   task automatic queue_event(input logic [1:0] f, input logic [31:0] idx,
                              input logic [7:0] ct, input logic [63:0] exp_v,
                              input logic [63:0] act_v, input logic [63:0] tm,
                              input logic [5:0] lim);
      req_item_t it;
      it.func  = f;
      it.idx   = idx;
      it.ct    = ct;
      it.exp_v = exp_v;
      it.act_v = act_v;
      it.tm    = tm;
      it.lim   = lim;
      pending_reqs.push_back(it);
      queued_total++;
   endtask

   task automatic queue_random(input logic [1:0] f);
      logic [7:0] ct;
      logic [5:0] lim;
      ct  = ($urandom_range(0, 3) == 0) ? restored_code : 8'($urandom);
      lim = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 8)) : 6'($urandom);
      queue_event(f, $urandom, ct, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, lim);
   endtask

   task automatic queue_mix(input int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) queue_random(FUNC_LOG);
         else if (roll < 88) queue_random(FUNC_READ);
         else if (roll < 95) queue_random(FUNC_CLEAR);
         else queue_random(FUNC_UNUSED);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (taken_total != queued_total || awaited_results.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_restored_code(input logic [7:0] code);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock);
      while (!csr_ready);
      restored_code = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty log, extremes, restored match, zero limit, unused code, clear
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd5);
      queue_event(FUNC_LOG, '0, 8'd2, '0, '0, '0, '0);
      queue_event(FUNC_LOG, '1, '1, '1, '1, '1, '1);
      queue_random(FUNC_LOG);
      queue_event(FUNC_READ, '1, '1, '1, '1, '1, 6'd0);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd63);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd1);
      queue_event(FUNC_UNUSED, '1, '1, '1, '1, '1, '1);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd2);
      queue_event(FUNC_CLEAR, '1, '1, '1, '1, '1, '1);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd63);
      queue_event(FUNC_LOG, 32'h1, 8'd1, 64'h1, 64'h2, 64'h3, '0);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd63);
      queue_event(FUNC_UNUSED, '0, '0, '0, '0, '0, '0);
      queue_event(FUNC_CLEAR, '0, '0, '0, '0, '0, '0);
      wait_idle();

      write_restored_code(8'd0);
      @(posedge clock);
      queue_mix(90);
      wait_idle();

      // wrap and overwrite: fill past capacity, then read everything
      write_restored_code(8'd255);
      @(posedge clock);
      repeat (75) queue_random(FUNC_LOG);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd63);
      queue_event(FUNC_READ, '0, '0, '0, '0, '0, 6'd40);
      repeat (3) queue_random(FUNC_LOG);
      queue_event(FUNC_READ, '1, '1, '1, '1, '1, 6'd63);
      queue_mix(40);
      wait_idle();

      write_restored_code(8'($urandom));
      @(posedge clock);
      queue_mix(100);
      wait_idle();

      calm = 1'b1;
      write_restored_code(RESTORED_CODE_RESET);
      @(posedge clock);
      queue_mix(50);
      wait_idle();
      repeat (20) @(negedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
